// ----- sv/roac_pkg.sv -----
// shared types, constants and helpers for the rectangle overlap area counter
package roac_pkg;

  // default grid size
  localparam int unsigned GRID_W_DEF = 1024;
  localparam int unsigned GRID_H_DEF = 1024;

  // item field widths
  localparam int unsigned COORD_W = 10;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned TOTAL_W = 21;

  // corner plus size reaches at most this many bits
  localparam int unsigned SUM_W = 12;

  // per-cell storage: saturating count plus generation tag
  localparam int unsigned CELL_W  = 2;
  localparam int unsigned EPOCH_W = 6;

  localparam logic [CELL_W-1:0]  CELL_MAX  = 2'd2;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // control from the sequencer to the cell update unit
  typedef struct packed {
    logic rd;         // read the cell at the scan address
    logic clr;        // clearing pass write at the scan address
    logic total_clr;  // zero the overlap total
  } cell_ctl_t;

  // bits needed to index n entries (at least one)
  function automatic int unsigned idx_bits(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // larger of two values
  function automatic int unsigned max2(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- sv/roac_cell_unit.sv -----
// coverage memory with one read-modify-write cell update per cycle and the overlap total
module roac_cell_unit
  import roac_pkg::*;
#(
  parameter int unsigned GRID_W = GRID_W_DEF,
  parameter int unsigned GRID_H = GRID_H_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  cell_ctl_t                                    ctl,
  input  logic [idx_bits(GRID_H)+idx_bits(GRID_W)-1:0] addr,
  input  logic [EPOCH_W-1:0]                           epoch,
  output logic [TOTAL_W-1:0]                           total
);

  localparam int unsigned CB    = idx_bits(GRID_W);
  localparam int unsigned RB    = idx_bits(GRID_H);
  localparam int unsigned AW    = RB + CB;
  localparam int unsigned DEPTH = GRID_H << CB;
  localparam int unsigned MW    = EPOCH_W + CELL_W;

  logic [MW-1:0]      mem [DEPTH];
  logic [MW-1:0]      rdata_r;
  logic [AW-1:0]      wb_addr_r;
  logic               wb_vld_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_nxt;

  logic [CELL_W-1:0]  cur_val;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [MW-1:0]      wr_data;

  // a cell tagged with an older generation counts as cleared
  always_comb begin
    cur_val = (rdata_r[MW-1:CELL_W] == epoch) ? rdata_r[CELL_W-1:0] : '0;
  end

  // single write port: clearing pass or write-back of the incremented count
  always_comb begin
    wr_en   = ctl.clr || (wb_vld_r && (cur_val < CELL_MAX));
    wr_addr = ctl.clr ? addr : wb_addr_r;
    wr_data = ctl.clr ? {epoch, {CELL_W{1'b0}}} : {epoch, cur_val + CELL_W'(1)};
  end

  // total rises when a cell steps from one to two, saturating
  always_comb begin
    total_nxt = total_r;
    if (ctl.total_clr) begin
      total_nxt = '0;
    end else if (wb_vld_r && (cur_val == CELL_MAX - CELL_W'(1)) && (total_r != TOTAL_MAX)) begin
      total_nxt = total_r + TOTAL_W'(1);
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered memory read and write-back address
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata_r <= mem[addr];
    end
    wb_addr_r <= addr;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_vld_r <= 1'b0;
      total_r  <= '0;
    end else begin
      wb_vld_r <= ctl.rd;
      total_r  <= total_nxt;
    end
  end

  assign total = total_r;

endmodule

// ----- sv/roac_scan.sv -----
// sequencer: item intake, clipping, cell scan, clearing pass and result register
module roac_scan
  import roac_pkg::*;
#(
  parameter int unsigned GRID_W = GRID_W_DEF,
  parameter int unsigned GRID_H = GRID_H_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic                                         in_new_set,
  input  logic [COORD_W-1:0]                           in_corner_x,
  input  logic [COORD_W-1:0]                           in_corner_y,
  input  logic [SIZE_W-1:0]                            in_width_cells,
  input  logic [SIZE_W-1:0]                            in_height_cells,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [TOTAL_W-1:0]                           out_overlap_total,
  output logic                                         out_clipped,
  output cell_ctl_t                                    ctl,
  output logic [idx_bits(GRID_H)+idx_bits(GRID_W)-1:0] addr,
  output logic [EPOCH_W-1:0]                           epoch,
  input  logic [TOTAL_W-1:0]                           total
);

  localparam int unsigned CB    = idx_bits(GRID_W);
  localparam int unsigned RB    = idx_bits(GRID_H);
  localparam int unsigned AW    = RB + CB;
  localparam int unsigned DEPTH = GRID_H << CB;
  localparam int unsigned CMPW  = max2(SUM_W, max2($clog2(GRID_W + 1), $clog2(GRID_H + 1)));

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic                scan_pend_r, scan_pend_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;
  logic                out_clip_r, out_clip_nxt;
  logic [CMPW-1:0]     x0_r, x0_nxt;
  logic [CMPW-1:0]     x1_r, x1_nxt;
  logic [CMPW-1:0]     y1_r, y1_nxt;
  logic [CMPW-1:0]     row_r, row_nxt;
  logic [CMPW-1:0]     col_r, col_nxt;
  logic                clip_r, clip_nxt;
  logic                empty_r, empty_nxt;

  logic                acc;
  logic [CMPW-1:0]     in_x0, in_y0, x1_sum, y1_sum, x1_lim, y1_lim;
  logic                clip_x, clip_y, nonzero, in_empty;
  logic [EPOCH_W-1:0]  epoch_inc;
  logic                slot_free;

  // clip the incoming rectangle against the grid
  always_comb begin
    in_x0    = CMPW'(in_corner_x);
    in_y0    = CMPW'(in_corner_y);
    x1_sum   = in_x0 + CMPW'(in_width_cells);
    y1_sum   = in_y0 + CMPW'(in_height_cells);
    clip_x   = x1_sum > CMPW'(GRID_W);
    clip_y   = y1_sum > CMPW'(GRID_H);
    x1_lim   = clip_x ? CMPW'(GRID_W) : x1_sum;
    y1_lim   = clip_y ? CMPW'(GRID_H) : y1_sum;
    nonzero  = (in_width_cells != '0) && (in_height_cells != '0);
    in_empty = (in_x0 >= x1_lim) || (in_y0 >= y1_lim);
  end

  assign acc       = in_valid && (state_r == S_IDLE);
  assign epoch_inc = epoch_r + EPOCH_W'(1);
  assign slot_free = !out_vld_r || out_ready;

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    epoch_nxt     = epoch_r;
    scan_pend_nxt = scan_pend_r;
    out_vld_nxt   = out_vld_r && !out_ready;
    out_total_nxt = out_total_r;
    out_clip_nxt  = out_clip_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    clip_nxt      = clip_r;
    empty_nxt     = empty_r;

    case (state_r)
      // walk every memory entry once
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          clr_cnt_nxt   = '0;
          scan_pend_nxt = 1'b0;
          if (!scan_pend_r) begin
            state_nxt = S_IDLE;
          end else if (empty_r) begin
            state_nxt = S_DRAIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      // take a new item
      S_IDLE: begin
        if (acc) begin
          x0_nxt    = in_x0;
          x1_nxt    = x1_lim;
          y1_nxt    = y1_lim;
          row_nxt   = in_y0;
          col_nxt   = in_x0;
          clip_nxt  = nonzero && (clip_x || clip_y);
          empty_nxt = in_empty;
          if (in_new_set) begin
            epoch_nxt = epoch_inc;
          end
          if (in_new_set && (epoch_inc == '0)) begin
            // generation tags wrapped: stale cells must be wiped
            clr_cnt_nxt   = '0;
            scan_pend_nxt = 1'b1;
            state_nxt     = S_CLEAR;
          end else if (in_empty) begin
            state_nxt = S_DRAIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      // one cell per cycle, row by row
      S_SCAN: begin
        if ((col_r + CMPW'(1)) == x1_r) begin
          col_nxt = x0_r;
          row_nxt = row_r + CMPW'(1);
          if ((row_r + CMPW'(1)) == y1_r) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          col_nxt = col_r + CMPW'(1);
        end
      end
      // last write-back lands
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (slot_free) begin
          out_vld_nxt   = 1'b1;
          out_total_nxt = total;
          out_clip_nxt  = clip_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, counters and result register
  always_ff @(posedge clk) begin
    x0_r        <= x0_nxt;
    x1_r        <= x1_nxt;
    y1_r        <= y1_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    clip_r      <= clip_nxt;
    empty_r     <= empty_nxt;
    out_total_r <= out_total_nxt;
    out_clip_r  <= out_clip_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      epoch_r     <= '0;
      scan_pend_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      epoch_r     <= epoch_nxt;
      scan_pend_r <= scan_pend_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // controls toward the cell unit
  always_comb begin
    ctl.rd        = (state_r == S_SCAN);
    ctl.clr       = (state_r == S_CLEAR);
    ctl.total_clr = acc && in_new_set;
    addr          = ctl.clr ? clr_cnt_r : {row_r[RB-1:0], col_r[CB-1:0]};
  end

  assign epoch             = epoch_r;
  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_vld_r;
  assign out_overlap_total = out_total_r;
  assign out_clipped       = out_clip_r;

endmodule

// ----- sv/rectangle_overlap_area_counter.sv -----
// Rectangle overlap area counter: rasterizes rectangles into saturating cell counters.
// Throughput: one cell read-modify-write per cycle through the single memory read/write pair.
// Every 64th new_set adds a clearing pass over all GRID_H * 2^ceil(log2(GRID_W)) memory entries.
// Reset: synchronous active low; then the same clearing pass runs over every memory entry
// before the first item is taken. A result may wait while the next item is accepted.
module rectangle_overlap_area_counter
  import roac_pkg::*;
#(
  parameter int unsigned GRID_W = GRID_W_DEF,
  parameter int unsigned GRID_H = GRID_H_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_new_set,
  input  logic [COORD_W-1:0] in_corner_x,
  input  logic [COORD_W-1:0] in_corner_y,
  input  logic [SIZE_W-1:0]  in_width_cells,
  input  logic [SIZE_W-1:0]  in_height_cells,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TOTAL_W-1:0] out_overlap_total,
  output logic               out_clipped
);

  localparam int unsigned AW = idx_bits(GRID_H) + idx_bits(GRID_W);

  cell_ctl_t          ctl;
  logic [AW-1:0]      addr;
  logic [EPOCH_W-1:0] epoch;
  logic [TOTAL_W-1:0] total;

  // sequencer
  roac_scan #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_scan (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_new_set        (in_new_set),
    .in_corner_x       (in_corner_x),
    .in_corner_y       (in_corner_y),
    .in_width_cells    (in_width_cells),
    .in_height_cells   (in_height_cells),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_overlap_total (out_overlap_total),
    .out_clipped       (out_clipped),
    .ctl               (ctl),
    .addr              (addr),
    .epoch             (epoch),
    .total             (total)
  );

  // coverage memory and total
  roac_cell_unit #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_cell (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .addr  (addr),
    .epoch (epoch),
    .total (total)
  );

  // clearing pass and cell reads never share a cycle
  a_clr_rd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |-> !ctl.rd)
    else $error("clearing write and cell read in the same cycle");

  // an accepted item always leaves the block busy on the next cycle
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block ready right after taking an item");

  // no new item while cells are being scanned or cleared
  a_no_take_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.rd || ctl.clr) |-> !in_ready)
    else $error("ready while the memory is busy");

  // total is only zeroed when a new set is taken
  a_total_clr_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.total_clr |-> (in_valid && in_ready && in_new_set))
    else $error("total cleared without a new set item");

endmodule

// ----- tb/sv/overlap_sb_pkg.sv -----
// item types and scoreboard class for the rectangle overlap counter bench
package overlap_sb_pkg;
  import roac_pkg::*;

  // one rectangle as accepted on the input channel
  typedef struct packed {
    logic               new_set;
    logic [COORD_W-1:0] corner_x;
    logic [COORD_W-1:0] corner_y;
    logic [SIZE_W-1:0]  width_cells;
    logic [SIZE_W-1:0]  height_cells;
  } rect_item_t;

  // one expected result item
  typedef struct packed {
    logic [TOTAL_W-1:0] overlap_total;
    logic               clipped;
  } overlap_result_t;

  class overlap_scoreboard;
    // sparse coverage grid: a missing entry is a zero count
    logic [CELL_W-1:0]  cell_cnt [int unsigned];
    logic [TOTAL_W-1:0] overlap_total;
    overlap_result_t    pending_totals [$];
    int unsigned        mismatches;

    function new();
      overlap_total = '0;
      mismatches    = 0;
    endfunction

    function int unsigned pending();
      return pending_totals.size();
    endfunction

    // rasterize one accepted rectangle and queue the total it leaves behind
    function void rasterize_rect(input rect_item_t r);
      int unsigned       x_end;
      int unsigned       y_end;
      int unsigned       row;
      int unsigned       col;
      int unsigned       idx;
      logic [CELL_W-1:0] cnt;
      overlap_result_t   res;
      res.clipped = 1'b0;
      if (r.new_set) begin
        cell_cnt.delete();
        overlap_total = '0;
      end
      // empty rectangles touch nothing and never clip
      if (r.width_cells != 0 && r.height_cells != 0) begin
        x_end = int'(r.corner_x) + int'(r.width_cells);
        y_end = int'(r.corner_y) + int'(r.height_cells);
        if (x_end > GRID_W_DEF) begin
          res.clipped = 1'b1;
          x_end = GRID_W_DEF;
        end
        if (y_end > GRID_H_DEF) begin
          res.clipped = 1'b1;
          y_end = GRID_H_DEF;
        end
        for (row = 32'(r.corner_y); row < y_end; row++) begin
          for (col = 32'(r.corner_x); col < x_end; col++) begin
            idx = row * GRID_W_DEF + col;
            cnt = cell_cnt.exists(idx) ? cell_cnt[idx] : '0;
            // counters hold at two; the total moves on the step to two
            if (cnt < CELL_MAX) begin
              cnt = cnt + CELL_W'(1);
              cell_cnt[idx] = cnt;
              if (cnt == CELL_MAX && overlap_total != TOTAL_MAX)
                overlap_total = overlap_total + TOTAL_W'(1);
            end
          end
        end
      end
      res.overlap_total = overlap_total;
      pending_totals.push_back(res);
    endfunction

    // compare one result item against the oldest expectation
    function void check_result(input logic [TOTAL_W-1:0] total, input logic clip);
      overlap_result_t exp_res;
      if (pending_totals.size() == 0) begin
        $error("result item with nothing pending: overlap_total %0d clipped %0d",
               total, clip);
        mismatches++;
        return;
      end
      exp_res = pending_totals.pop_front();
      if (total !== exp_res.overlap_total) begin
        $error("overlap_total mismatch: expected %0d, actual %0d",
               exp_res.overlap_total, total);
        mismatches++;
      end
      if (clip !== exp_res.clipped) begin
        $error("clipped mismatch: expected %0d, actual %0d", exp_res.clipped, clip);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/testbench.sv -----
// top-level bench: drives rectangles into the overlap counter and checks every total
module testbench;
  import roac_pkg::*;
  import overlap_sb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned QUIET_TAIL   = 60;
  localparam int unsigned MAX_CLEARS   = 60;
  localparam int unsigned CYCLE_LIMIT  = 8000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_new_set = 1'b0;
  logic [COORD_W-1:0] in_corner_x = '0;
  logic [COORD_W-1:0] in_corner_y = '0;
  logic [SIZE_W-1:0]  in_width_cells = '0;
  logic [SIZE_W-1:0]  in_height_cells = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [TOTAL_W-1:0] out_overlap_total;
  logic               out_clipped;

  overlap_scoreboard overlap_sb;
  bit                sender_gaps = 1'b0;
  bit                stall_on = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       cycle_count = 0;
  int unsigned       clears_used = 0;

  rectangle_overlap_area_counter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_new_set       (in_new_set),
    .in_corner_x      (in_corner_x),
    .in_corner_y      (in_corner_y),
    .in_width_cells   (in_width_cells),
    .in_height_cells  (in_height_cells),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_overlap_total(out_overlap_total),
    .out_clipped      (out_clipped)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      overlap_sb.check_result(out_overlap_total, out_clipped);
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 15) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // present one rectangle, optionally after an idle burst, and wait for the handshake
  task automatic send_rect(input logic ns, input int unsigned x, input int unsigned y,
                           input int unsigned w, input int unsigned h);
    rect_item_t r;
    // clears past the cap would trigger extra full-grid clearing passes
    if (ns && clears_used >= MAX_CLEARS) ns = 1'b0;
    if (ns) clears_used++;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    r.new_set      = ns;
    r.corner_x     = x[COORD_W-1:0];
    r.corner_y     = y[COORD_W-1:0];
    r.width_cells  = w[SIZE_W-1:0];
    r.height_cells = h[SIZE_W-1:0];
    in_valid        <= 1'b1;
    in_new_set      <= r.new_set;
    in_corner_x     <= r.corner_x;
    in_corner_y     <= r.corner_y;
    in_width_cells  <= r.width_cells;
    in_height_cells <= r.height_cells;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    overlap_sb.rasterize_rect(r);
  endtask

  // hold the sender until every pending total has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (overlap_sb.pending() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int unsigned random_sent;
    int unsigned set_idx;
    int unsigned set_len;
    int unsigned base_x;
    int unsigned base_y;
    int unsigned kind;
    int unsigned x;
    int unsigned y;
    int unsigned w;
    int unsigned h;
    logic        ns;
    bit          quiet;

    overlap_sb = new();
    random_sent = 0;
    set_idx = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: saturation, overlap steps, empty and clipped shapes, field extremes
    sender_gaps = 1'b1;
    stall_on = 1'b1;
    send_rect(1'b1, 0, 0, 1, 1);
    send_rect(1'b0, 0, 0, 1, 1);
    send_rect(1'b0, 0, 0, 1, 1);
    send_rect(1'b0, 0, 0, 2, 2);
    send_rect(1'b0, 1, 1, 2, 2);
    send_rect(1'b0, 1023, 1023, 0, 5);
    send_rect(1'b0, 1023, 1023, 5, 0);
    send_rect(1'b0, 0, 0, 0, 0);
    send_rect(1'b0, 1023, 0, 2047, 1);
    send_rect(1'b0, 1023, 0, 1, 1);
    send_rect(1'b0, 0, 1023, 2047, 1);
    send_rect(1'b0, 0, 1023, 1024, 1);
    send_rect(1'b0, 1020, 1020, 2047, 2047);
    send_rect(1'b0, 1023, 1023, 2047, 2047);
    send_rect(1'b0, 0, 0, 1024, 2);
    send_rect(1'b0, 5, 0, 1, 1024);
    send_rect(1'b0, 6, 1, 1, 1025);
    send_rect(1'b0, 0, 700, 1536, 1);
    send_rect(1'b0, 900, 100, 1, 1536);
    send_rect(1'b1, 0, 0, 0, 0);
    send_rect(1'b1, 512, 512, 3, 3);
    send_rect(1'b0, 513, 513, 3, 3);
    drain_results();

    // random sets of rectangles clustered around a window, plus noise
    while (random_sent < RANDOM_ITEMS) begin
      quiet = (random_sent >= RANDOM_ITEMS - QUIET_TAIL);
      sender_gaps = !quiet && ($urandom_range(0, 2) != 0);
      stall_on = !quiet && ($urandom_range(0, 2) != 0);
      if (set_idx == 10) drain_results();
      set_len = $urandom_range(6, 20);
      base_x = $urandom_range(0, 1023);
      base_y = $urandom_range(0, 1023);
      for (int unsigned i = 0; i < set_len && random_sent < RANDOM_ITEMS; i++) begin
        if (i == 0)
          ns = ($urandom_range(0, 6) != 0);
        else
          ns = ($urandom_range(0, 49) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          // overlapping rectangles inside the set's window
          x = base_x + $urandom_range(0, 40);
          y = base_y + $urandom_range(0, 40);
          if (x > 1023) x = 1023;
          if (y > 1023) y = 1023;
          w = $urandom_range(1, 24);
          h = $urandom_range(1, 24);
        end else if (kind < 80) begin
          x = $urandom_range(0, 1023);
          y = $urandom_range(0, 1023);
          w = $urandom_range(1, 32);
          h = $urandom_range(1, 32);
        end else if (kind < 88) begin
          // long thin strip, either direction
          x = $urandom_range(0, 1023);
          y = $urandom_range(0, 1023);
          if ($urandom_range(0, 1) != 0) begin
            w = $urandom_range(0, 2047);
            h = $urandom_range(1, 2);
          end else begin
            w = $urandom_range(1, 2);
            h = $urandom_range(0, 2047);
          end
        end else if (kind < 94) begin
          // empty rectangle
          x = $urandom_range(0, 1023);
          y = $urandom_range(0, 1023);
          if ($urandom_range(0, 1) != 0) begin
            w = 0;
            h = $urandom_range(0, 2047);
          end else begin
            w = $urandom_range(0, 2047);
            h = 0;
          end
        end else begin
          // oversized near the far corner, mostly clipped
          x = $urandom_range(990, 1023);
          y = $urandom_range(990, 1023);
          w = $urandom_range(25, 2047);
          h = $urandom_range(25, 2047);
        end
        send_rect(ns, x, y, w, h);
        random_sent++;
      end
      set_idx++;
    end

    // wait out the last totals
    drain_results();
    stall_on = 1'b0;
    repeat (16) @(posedge clk);
    if (overlap_sb.mismatches == 0 && overlap_sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
